FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/stl_pkg.sv
// types, constants and helper functions of the source token lexer
`timescale 1ns / 1ps

package stl_pkg;

    localparam int CNT_BITS      = 16;
    localparam int KIND_BITS     = 6;
    localparam int KW_LEN        = 6;
    localparam int KW_BITS       = 8 * KW_LEN;
    localparam int N_KW          = 11;
    localparam int MAX_TOKENS    = 4;
    localparam int TOK_CNT_BITS  = $clog2(MAX_TOKENS + 1);
    localparam int TOK_IDX_BITS  = $clog2(MAX_TOKENS);
    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_DATA_BITS = 3 * CNT_BITS;

    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [KIND_BITS-1:0] kind_t;

    localparam kind_t K_DOT    = 6'd9;
    localparam kind_t K_CMP0   = 6'd11;
    localparam kind_t K_NUMBER = 6'd19;
    localparam kind_t K_IDENT  = 6'd20;
    localparam kind_t K_KEY0   = 6'd21;
    localparam kind_t K_EOF    = 6'd32;
    localparam kind_t K_ERROR  = 6'd33;

    // keyword text, first character in the top byte, zero padded
    localparam logic [KW_BITS-1:0] KW_TEXT [N_KW] = '{
        "struct",
        {"else", 16'h0000},
        {"false", 8'h00},
        {"for", 24'h000000},
        {"fn", 32'h00000000},
        {"if", 32'h00000000},
        {"print", 8'h00},
        "return",
        {"true", 16'h0000},
        {"let", 24'h000000},
        {"while", 8'h00}
    };

    typedef struct packed {
        kind_t kind;
        cnt_t  line;
        cnt_t  col;
        cnt_t  len;
    } tok_t;

    typedef struct packed {
        tok_t [MAX_TOKENS-1:0]   tok;
        logic [TOK_CNT_BITS-1:0] cnt;
    } tok_group_t;

    function automatic cnt_t sat_add(cnt_t v, logic [1:0] d);
        logic [CNT_BITS:0] s;
        s = {1'b0, v} + (CNT_BITS + 1)'(d);
        return s[CNT_BITS] ? '1 : s[CNT_BITS-1:0];
    endfunction

    // identifier buffer holds the first character in the lowest byte
    function automatic kind_t keyword_kind(logic [KW_BITS-1:0] word_bytes, logic too_long);
        logic [KW_BITS-1:0] text;
        kind_t              kind;
        for (int i = 0; i < KW_LEN; i++) begin
            text[KW_BITS-1-8*i -: 8] = word_bytes[8*i +: 8];
        end
        kind = K_IDENT;
        if (!too_long) begin
            for (int k = 0; k < N_KW; k++) begin
                if (text == KW_TEXT[k]) begin
                    kind = K_KEY0 + kind_t'(k);
                end
            end
        end
        return kind;
    endfunction

endpackage

FILE: design/stl_scan.sv
// scanner state and the per-byte step that builds a group of tokens
`timescale 1ns / 1ps

module stl_scan (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic [stl_pkg::IN_DATA_BITS-1:0] char_code,
    input  logic                              end_of_source,
    output stl_pkg::tok_group_t               group
);
    import stl_pkg::*;

    typedef enum logic [5:0] {
        PC_NONE  = 6'b000001,
        PC_OP    = 6'b000010,
        PC_INT   = 6'b000100,
        PC_DOT   = 6'b001000,
        PC_FRAC  = 6'b010000,
        PC_IDENT = 6'b100000
    } pend_t;

    typedef struct packed {
        tok_t       t0;
        tok_t       t1;
        logic [1:0] n;
    } flush_t;

    pend_t              pc_reg,   pc_next;
    logic [1:0]         pop_reg,  pop_next;
    cnt_t               line_reg, line_next;
    cnt_t               col_reg,  col_next;
    cnt_t               tsc_reg,  tsc_next;
    cnt_t               tlen_reg, tlen_next;
    logic [KW_BITS-1:0] ibuf_reg, ibuf_next;
    logic               itl_reg,  itl_next;

    kind_t kw_old;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic kind_t cmp_kind(logic [1:0] op, logic eq);
        return K_CMP0 + kind_t'({op, eq});
    endfunction

    function automatic logic [KIND_BITS:0] single_op(logic [7:0] c);
        logic [KIND_BITS:0] r;
        unique case (c)
            "(":     r = {1'b1, 6'd0};
            ")":     r = {1'b1, 6'd1};
            "{":     r = {1'b1, 6'd2};
            "}":     r = {1'b1, 6'd3};
            "+":     r = {1'b1, 6'd4};
            "-":     r = {1'b1, 6'd5};
            "*":     r = {1'b1, 6'd6};
            "/":     r = {1'b1, 6'd7};
            ",":     r = {1'b1, 6'd8};
            ".":     r = {1'b1, K_DOT};
            ";":     r = {1'b1, 6'd10};
            default: r = '0;
        endcase
        return r;
    endfunction

    // tokens of the pending lexeme when no further byte can extend it
    function automatic flush_t flush_tokens(pend_t pc, logic [1:0] op, cnt_t line, cnt_t tsc,
                                            cnt_t tlen, cnt_t colc, kind_t ident_k);
        flush_t f;
        f = '0;
        unique case (pc)
            PC_OP: begin
                f.t0 = '{cmp_kind(op, 1'b0), line, tsc, cnt_t'(1)};
                f.n  = 2'd1;
            end
            PC_INT, PC_FRAC: begin
                f.t0 = '{K_NUMBER, line, tsc, tlen};
                f.n  = 2'd1;
            end
            PC_DOT: begin
                f.t0 = '{K_NUMBER, line, tsc, tlen};
                f.t1 = '{K_DOT, line, colc, cnt_t'(1)};
                f.n  = 2'd2;
            end
            PC_IDENT: begin
                f.t0 = '{ident_k, line, tsc, tlen};
                f.n  = 2'd1;
            end
            PC_NONE: ;
            default: ;
        endcase
        return f;
    endfunction

    assign kw_old = keyword_kind(ibuf_reg, itl_reg);

    always_comb begin
        cnt_t                       col;
        logic                       consumed;
        logic                       need_flush;
        logic [TOK_CNT_BITS-1:0]    n;
        tok_t [MAX_TOKENS-1:0]      toks;
        flush_t                     f;
        logic [KIND_BITS:0]         op;
        kind_t                      kw_new;
        cnt_t                       eof_col;

        col        = sat_add(col_reg, 2'd1);
        pc_next    = pc_reg;
        pop_next   = pop_reg;
        line_next  = line_reg;
        tsc_next   = tsc_reg;
        tlen_next  = tlen_reg;
        ibuf_next  = ibuf_reg;
        itl_next   = itl_reg;
        consumed   = 1'b0;
        need_flush = 1'b0;
        n          = '0;
        toks       = '0;
        f          = '0;
        kw_new     = K_IDENT;
        eof_col    = '0;
        op         = single_op(char_code);

        unique case (pc_reg)
            PC_OP: begin
                if (char_code == "=") begin
                    toks[n[TOK_IDX_BITS-1:0]] = '{cmp_kind(pop_reg, 1'b1), line_reg, tsc_reg,
                                                  cnt_t'(2)};
                    n        = n + 1'b1;
                    pc_next  = PC_NONE;
                    consumed = 1'b1;
                end else begin
                    need_flush = 1'b1;
                end
            end
            PC_INT: begin
                if (is_digit(char_code)) begin
                    tlen_next = sat_add(tlen_reg, 2'd1);
                    consumed  = 1'b1;
                end else if (char_code == ".") begin
                    pc_next  = PC_DOT;
                    consumed = 1'b1;
                end else begin
                    need_flush = 1'b1;
                end
            end
            PC_DOT: begin
                if (is_digit(char_code)) begin
                    tlen_next = sat_add(tlen_reg, 2'd2);
                    pc_next   = PC_FRAC;
                    consumed  = 1'b1;
                end else begin
                    need_flush = 1'b1;
                end
            end
            PC_FRAC: begin
                if (is_digit(char_code)) begin
                    tlen_next = sat_add(tlen_reg, 2'd1);
                    consumed  = 1'b1;
                end else begin
                    need_flush = 1'b1;
                end
            end
            PC_IDENT: begin
                if (is_alpha(char_code) || is_digit(char_code)) begin
                    for (int i = 0; i < KW_LEN; i++) begin
                        if (tlen_reg == cnt_t'(i)) begin
                            ibuf_next[8*i +: 8] = char_code;
                        end
                    end
                    if (tlen_reg >= cnt_t'(KW_LEN)) begin
                        itl_next = 1'b1;
                    end
                    tlen_next = sat_add(tlen_reg, 2'd1);
                    consumed  = 1'b1;
                end else begin
                    need_flush = 1'b1;
                end
            end
            PC_NONE: ;
            default: ;
        endcase

        if (need_flush) begin
            f = flush_tokens(pc_reg, pop_reg, line_reg, tsc_reg, tlen_reg, col_reg, kw_old);
            for (int i = 0; i < 2; i++) begin
                if (2'(i) < f.n) begin
                    toks[n[TOK_IDX_BITS-1:0]] = (i == 0) ? f.t0 : f.t1;
                    n = n + 1'b1;
                end
            end
            pc_next = PC_NONE;
        end

        if (!consumed) begin
            tsc_next = col;
            if (op[KIND_BITS]) begin
                toks[n[TOK_IDX_BITS-1:0]] = '{op[KIND_BITS-1:0], line_next, col, cnt_t'(1)};
                n = n + 1'b1;
            end else if (char_code == "!" || char_code == "=" || char_code == "<" ||
                         char_code == ">") begin
                pop_next = (char_code == "!") ? 2'd0 :
                           (char_code == "=") ? 2'd1 :
                           (char_code == "<") ? 2'd2 : 2'd3;
                pc_next  = PC_OP;
            end else if (char_code == " ") begin
                pc_next = pc_next;
            end else if (char_code == 8'h0a) begin
                line_next = sat_add(line_reg, 2'd1);
                col       = '0;
                tsc_next  = '0;
            end else if (is_digit(char_code)) begin
                pc_next   = PC_INT;
                tlen_next = cnt_t'(1);
            end else if (is_alpha(char_code)) begin
                pc_next   = PC_IDENT;
                ibuf_next = {{(KW_BITS-8){1'b0}}, char_code};
                itl_next  = 1'b0;
                tlen_next = cnt_t'(1);
            end else begin
                toks[n[TOK_IDX_BITS-1:0]] = '{K_ERROR, line_next, col, cnt_t'(1)};
                n = n + 1'b1;
            end
        end
        col_next = col;

        if (end_of_source) begin
            kw_new = keyword_kind(ibuf_next, itl_next);
            f = flush_tokens(pc_next, pop_next, line_next, tsc_next, tlen_next, col, kw_new);
            for (int i = 0; i < 2; i++) begin
                if (2'(i) < f.n) begin
                    toks[n[TOK_IDX_BITS-1:0]] = (i == 0) ? f.t0 : f.t1;
                    n = n + 1'b1;
                end
            end
            eof_col = (pc_next == PC_DOT) ? col : tsc_next;
            toks[n[TOK_IDX_BITS-1:0]] = '{K_EOF, line_next, eof_col, cnt_t'(0)};
            n = n + 1'b1;
            // next byte opens a new source
            pc_next   = PC_NONE;
            pop_next  = '0;
            line_next = cnt_t'(1);
            col_next  = '0;
            tsc_next  = '0;
            tlen_next = '0;
            ibuf_next = '0;
            itl_next  = 1'b0;
        end

        group.tok = toks;
        group.cnt = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= PC_NONE;
            pop_reg  <= '0;
            line_reg <= cnt_t'(1);
            col_reg  <= '0;
            tsc_reg  <= '0;
            tlen_reg <= '0;
            ibuf_reg <= '0;
            itl_reg  <= 1'b0;
        end else if (accept) begin
            pc_reg   <= pc_next;
            pop_reg  <= pop_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            tsc_reg  <= tsc_next;
            tlen_reg <= tlen_next;
            ibuf_reg <= ibuf_next;
            itl_reg  <= itl_next;
        end
    end

endmodule

FILE: design/source_token_lexer.sv
// top level of the source token lexer: scanner plus token group output buffer
`timescale 1ns / 1ps

// channel  dir  data                                         user              marker
// s_       in   tdata[7:0] char_code                         -                 tlast end_of_source
// m_       out  tdata[15:0] line [31:16] column [47:32] len  tuser[5:0] kind   tlast last token
//                                                                              of the byte
//
// one source byte per cycle while m_tready is high and no byte yields more than one token;
// a byte that yields n tokens holds the buffer until all n are taken, and the next byte
// is taken in the cycle its last token is taken; bytes that yield no token pass without
// occupying the output; aresetn is synchronous, active low; it clears scanner state and drops m_tvalid
// m_tready low stalls the input once a token is waiting

module source_token_lexer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [stl_pkg::IN_DATA_BITS-1:0]  s_tdata,   // char_code
    input  logic                               s_tlast,   // end_of_source
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stl_pkg::OUT_DATA_BITS-1:0] m_tdata,   // line_number, start_column,
                                                          // token_length
    output logic [stl_pkg::KIND_BITS-1:0]     m_tuser,   // token_kind
    output logic                               m_tlast    // last_result
);
    import stl_pkg::*;

    tok_group_t                 group;
    tok_t [MAX_TOKENS-1:0]      grp_reg,  grp_next;
    logic [TOK_CNT_BITS-1:0]    cnt_reg,  cnt_next;
    logic [TOK_IDX_BITS-1:0]    idx_reg,  idx_next;

    logic s_take;
    logic m_take;
    logic at_last;
    tok_t head;

    stl_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_take),
        .char_code     (s_tdata),
        .end_of_source (s_tlast),
        .group         (group)
    );

    assign head     = grp_reg[idx_reg];
    assign at_last  = ({1'b0, idx_reg} == (cnt_reg - 1'b1));
    assign m_tvalid = (cnt_reg != '0);
    assign m_take   = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == '0) || (m_take && at_last);
    assign s_take   = s_tvalid && s_tready;

    assign m_tdata  = {head.len, head.col, head.line};
    assign m_tuser  = head.kind;
    assign m_tlast  = at_last;

    always_comb begin
        grp_next = grp_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (s_take) begin
            grp_next = group.tok;
            cnt_next = group.cnt;
            idx_next = '0;
        end else if (m_take) begin
            if (at_last) begin
                cnt_next = '0;
                idx_next = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg <= grp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

endmodule

FILE: design/stl_checker.sv
// port-level assertions for the source token lexer and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stl_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               s_tlast,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [stl_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input logic [stl_pkg::KIND_BITS-1:0]     m_tuser,
    input logic                               m_tlast
);
    import stl_pkg::*;

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled token changed")

    `ASSERT_IMPLIES(a_stall_has_token, aclk, aresetn, !s_tready, m_tvalid,
        "input stalled with no token waiting")

    `ASSERT_IMPLIES(a_ready_on_drain, aclk, aresetn, s_tready && m_tvalid,
        m_tlast && m_tready, "input ready while tokens of a byte remain")

    `ASSERT_IMPLIES(a_eof_last, aclk, aresetn, m_tvalid && (m_tuser == K_EOF),
        m_tlast && (m_tdata[47:32] == 16'd0), "eof token not last or not empty")

    `ASSERT_NEXT(a_eof_follows, aclk, aresetn, s_tvalid && s_tready && s_tlast,
        m_tvalid, "end of source gave no token")

endmodule

bind source_token_lexer stl_checker u_stl_checker (.*);

FILE: tb/tb_top.sv
// testbench for the source token lexer: directed and random byte streams against a scanner model
`timescale 1ns / 1ps

module tb_top;
    import stl_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_SP  = " ";
    localparam logic [7:0] CH_EQ  = "=";
    localparam logic [7:0] CH_DOT = ".";

    typedef enum logic [2:0] {SC_NONE, SC_OP, SC_INT, SC_DOT, SC_FRAC, SC_IDENT} scan_state_t;

    typedef struct packed {
        kind_t kind;
        cnt_t  line;
        cnt_t  col;
        cnt_t  len;
        logic  last;
    } token_t;

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic                     s_tlast  = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [KIND_BITS-1:0]     m_tuser;
    logic                     m_tlast;

    int errors      = 0;
    int cycle_count = 0;
    int send_idle   = 0;
    int recv_stall  = 0;
    int hold_count  = 0;
    bit hold_on     = 1'b0;

    string single_ops = "(){}+-*/,.;";
    string op_chars   = "(){}+-*/,.;!=<>";
    string kw_names [N_KW] = '{"struct", "else", "false", "for", "fn", "if",
                               "print", "return", "true", "let", "while"};

    // scanner model state
    scan_state_t         scan_state;
    logic [1:0]          cmp_op;
    cnt_t                line_cnt;
    cnt_t                col_cnt;
    cnt_t                tok_start;
    cnt_t                tok_len;
    logic [KW_BITS-1:0]  word_bytes;
    logic                word_long;
    token_t              fresh_q[$];
    token_t              token_q[$];
    logic [7:0]          src_q[$];

    source_token_lexer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic cnt_t bump(cnt_t v, int unsigned d);
        int unsigned s;
        s = v + d;
        return (s > 32'hFFFF) ? 16'hFFFF : cnt_t'(s);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_start(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic void clear_scanner();
        scan_state = SC_NONE;
        cmp_op     = '0;
        line_cnt   = 16'd1;
        col_cnt    = '0;
        tok_start  = '0;
        tok_len    = '0;
        word_bytes = '0;
        word_long  = 1'b0;
    endfunction

    function automatic void push_token(kind_t kind, cnt_t col, cnt_t len);
        if (fresh_q.size() < MAX_TOKENS) begin
            fresh_q.insert(fresh_q.size(), token_t'{kind, line_cnt, col, len, 1'b0});
        end
    endfunction

    function automatic kind_t word_kind();
        logic [KW_BITS-1:0] kw_word;
        kind_t              kind;
        kind = K_IDENT;
        if (!word_long) begin
            for (int k = 0; k < N_KW; k++) begin
                kw_word = '0;
                for (int i = 0; i < kw_names[k].len(); i++) begin
                    kw_word[8*i +: 8] = kw_names[k][i];
                end
                if (kw_word == word_bytes) begin
                    kind = K_KEY0 + kind_t'(k);
                end
            end
        end
        return kind;
    endfunction

    function automatic void word_add(logic [7:0] c);
        if (tok_len < KW_LEN) begin
            word_bytes[8*tok_len +: 8] = c;
        end else begin
            word_long = 1'b1;
        end
        tok_len = bump(tok_len, 1);
    endfunction

    // emit the pending token as if nothing could extend it
    function automatic void flush_pending();
        case (scan_state)
            SC_OP: begin
                push_token(K_CMP0 + kind_t'(2 * cmp_op), tok_start, 16'd1);
            end
            SC_INT, SC_FRAC: begin
                push_token(K_NUMBER, tok_start, tok_len);
            end
            SC_DOT: begin
                push_token(K_NUMBER, tok_start, tok_len);
                tok_start = col_cnt;
                push_token(K_DOT, tok_start, 16'd1);
            end
            SC_IDENT: begin
                push_token(word_kind(), tok_start, tok_len);
            end
            default: begin
            end
        endcase
        scan_state = SC_NONE;
    endfunction

    // model one accepted request and queue the tokens it yields
    function automatic void scan_byte(logic [7:0] c, logic eos);
        cnt_t col;
        logic used;
        logic done;
        col  = bump(col_cnt, 1);
        used = 1'b0;
        done = 1'b0;
        fresh_q.delete();
        case (scan_state)
            SC_OP: begin
                if (c == CH_EQ) begin
                    push_token(K_CMP0 + kind_t'(1 + 2 * cmp_op), tok_start, 16'd2);
                    scan_state = SC_NONE;
                    used = 1'b1;
                end else begin
                    flush_pending();
                end
            end
            SC_INT: begin
                if (is_digit(c)) begin
                    tok_len = bump(tok_len, 1);
                    used = 1'b1;
                end else if (c == CH_DOT) begin
                    scan_state = SC_DOT;
                    used = 1'b1;
                end else begin
                    flush_pending();
                end
            end
            SC_DOT: begin
                if (is_digit(c)) begin
                    tok_len = bump(tok_len, 2);
                    scan_state = SC_FRAC;
                    used = 1'b1;
                end else begin
                    flush_pending();
                end
            end
            SC_FRAC: begin
                if (is_digit(c)) begin
                    tok_len = bump(tok_len, 1);
                    used = 1'b1;
                end else begin
                    flush_pending();
                end
            end
            SC_IDENT: begin
                if (is_word_start(c) || is_digit(c)) begin
                    word_add(c);
                    used = 1'b1;
                end else begin
                    flush_pending();
                end
            end
            default: begin
                scan_state = SC_NONE;
            end
        endcase

        if (!used) begin
            tok_start = col;
            for (int k = 0; k < single_ops.len(); k++) begin
                if (!done && c == single_ops[k]) begin
                    push_token(kind_t'(k), col, 16'd1);
                    done = 1'b1;
                end
            end
            if (!done) begin
                case (c)
                    "!": begin cmp_op = 2'd0; scan_state = SC_OP; end
                    "=": begin cmp_op = 2'd1; scan_state = SC_OP; end
                    "<": begin cmp_op = 2'd2; scan_state = SC_OP; end
                    ">": begin cmp_op = 2'd3; scan_state = SC_OP; end
                    CH_SP: begin
                    end
                    CH_NL: begin
                        line_cnt  = bump(line_cnt, 1);
                        col       = '0;
                        tok_start = '0;
                    end
                    default: begin
                        if (is_digit(c)) begin
                            scan_state = SC_INT;
                            tok_len    = 16'd1;
                        end else if (is_word_start(c)) begin
                            scan_state = SC_IDENT;
                            tok_len    = '0;
                            word_bytes = '0;
                            word_long  = 1'b0;
                            word_add(c);
                        end else begin
                            push_token(K_ERROR, col, 16'd1);
                        end
                    end
                endcase
            end
        end
        col_cnt = col;

        if (eos) begin
            flush_pending();
            push_token(K_EOF, tok_start, '0);
            clear_scanner();
        end

        if (fresh_q.size() > 0) begin
            fresh_q[fresh_q.size() - 1].last = 1'b1;
        end
        foreach (fresh_q[i]) begin
            token_q.insert(token_q.size(), fresh_q[i]);
        end
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic eos);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        scan_byte(c, eos);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], close && i == s.len() - 1);
        end
    endtask

    task automatic close_phase();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (token_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    function automatic logic [7:0] word_char(bit any_pos);
        int r;
        r = $urandom_range(any_pos ? 62 : 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return "_";
        return 8'("0" + r - 53);
    endfunction

    function automatic void add_byte(logic [7:0] c);
        src_q.insert(src_q.size(), c);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i]);
        end
    endfunction

    function automatic void add_lexeme();
        int pick;
        int n;
        int k;
        pick = $urandom_range(99);
        if (pick < 15) begin
            add_text(kw_names[$urandom_range(N_KW - 1)]);
            if ($urandom_range(4) == 0) begin
                add_byte(word_char(1'b1));
            end
        end else if (pick < 30) begin
            n = $urandom_range(1, 9);
            add_byte(word_char(1'b0));
            for (int i = 1; i < n; i++) begin
                add_byte(word_char(1'b1));
            end
        end else if (pick < 45) begin
            repeat ($urandom_range(1, 4)) add_byte(8'("0" + $urandom_range(9)));
            if ($urandom_range(1)) begin
                add_byte(CH_DOT);
                if ($urandom_range(9) < 7) begin
                    repeat ($urandom_range(1, 3)) add_byte(8'("0" + $urandom_range(9)));
                end
            end
        end else if (pick < 65) begin
            k = $urandom_range(op_chars.len() - 1);
            add_byte(op_chars[k]);
            if (k >= single_ops.len() && $urandom_range(1)) begin
                add_byte(CH_EQ);
            end
        end else if (pick < 85) begin
            add_byte(($urandom_range(3) == 0) ? CH_NL : CH_SP);
        end else begin
            add_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(1)) begin
            add_byte(CH_SP);
        end
    endfunction

    task automatic test_operators();
        send_text("(){}+-*/,.;!!=<<=>>===", 1'b1);
        close_phase();
    endtask

    task automatic test_numbers();
        send_text("12.5 3.x 7.", 1'b1);
        close_phase();
    endtask

    task automatic test_unknown_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte("@", 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NL, 1'b1);
        close_phase();
    endtask

    task automatic test_identifiers();
        send_text("struct structs _Ab9 fo", 1'b1);
        send_text("x", 1'b1);
        close_phase();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_bytes);
        int sent;
        sent       = 0;
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        while (sent < n_bytes) begin
            src_q.delete();
            repeat ($urandom_range(1, 8)) add_lexeme();
            foreach (src_q[i]) begin
                send_byte(src_q[i], i == src_q.size() - 1);
            end
            sent += src_q.size();
        end
        close_phase();
    endtask

    // receiver held off while dense operator traffic fills the block
    task automatic test_backpressure();
        send_idle  = 0;
        recv_stall = 0;
        hold_on    = 1'b1;
        for (int i = 0; i < 50; i++) begin
            send_byte(op_chars[$urandom_range(op_chars.len() - 1)], i == 49);
        end
        close_phase();
    endtask

    always @(posedge aclk) begin
        if (hold_on && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        token_t got;
        token_t want;
        got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tlast};
        if (aresetn && m_tvalid && m_tready) begin
            if (token_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected token kind %0d line %0d col %0d len %0d last %0d",
                         $time, got.kind, got.line, got.col, got.len, got.last);
            end else begin
                want = token_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display({"%0t: expected kind %0d line %0d col %0d len %0d last %0d,",
                              " got kind %0d line %0d col %0d len %0d last %0d"},
                             $time, want.kind, want.line, want.col, want.len, want.last,
                             got.kind, got.line, got.col, got.len, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        clear_scanner();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_operators();
        test_numbers();
        test_unknown_bytes();
        test_identifiers();
        test_random_traffic(0, 0, 80);
        test_random_traffic(80, 0, 80);
        test_random_traffic(0, 80, 80);
        test_random_traffic(20, 20, 80);
        test_backpressure();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/stl_pkg.sv
design/stl_scan.sv
design/source_token_lexer.sv
design/stl_checker.sv
tb/tb_top.sv
